[rtl/gprd_pkg.sv]
// ----------------------------------------------------------------------------
// gprd_pkg
// shared constants and types of the gamepad report decoder
// ----------------------------------------------------------------------------
`default_nettype none

package gprd_pkg;

    // report bytes that decoding looks at
    localparam int KEEP_BYTES   = 18;
    localparam int REPORT_BYTES = 18;

    // pad kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LEGACY = 2'd1;
    localparam logic [1:0] KIND_GIP    = 2'd2;

    // configuration register indexes
    localparam logic CFG_PAD_KIND  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd64;

    // report ids and flags
    localparam logic [7:0] LEGACY_ID       = 8'h00;
    localparam logic [7:0] LEGACY_MIN_SIZE = 8'h14;
    localparam logic [7:0] GIP_INPUT_ID    = 8'h20;
    localparam logic [7:0] GIP_GUIDE_ID    = 8'h07;
    localparam int         GIP_ACK_BIT     = 4;

    // minimum report lengths
    localparam int LEGACY_MIN_LEN = 14;
    localparam int GIP_ACK_LEN    = 4;
    localparam int GIP_GUIDE_LEN  = 5;
    localparam int GIP_INPUT_LEN  = 18;

    // button bit positions
    localparam int BTN_GUIDE = 10;
    localparam int BTN_L2    = 15;
    localparam int BTN_R2    = 16;
    localparam int BTN_W     = 17;

    localparam int OUT_DATA_W = 128;

    typedef logic [KEEP_BYTES-1:0][7:0] report_t;

    typedef struct packed {
        logic [BTN_W-1:0]   buttons;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } record_t;

    typedef struct packed {
        record_t    rec;
        logic       state_changed;
        logic       ack_needed;
        logic [7:0] ack_command;
        logic [7:0] ack_sequence;
        logic [7:0] ack_length;
    } result_t;

endpackage

`default_nettype wire

[rtl/gprd_buffer.sv]
// ----------------------------------------------------------------------------
// gprd_buffer
// collects report bytes and presents the report including the current byte
// ----------------------------------------------------------------------------
`default_nettype none

module gprd_buffer #(
    parameter int REPORT_BYTES = gprd_pkg::REPORT_BYTES,
    parameter int CNT_W        = $clog2(REPORT_BYTES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last,
    output gprd_pkg::report_t      report,
    output logic [CNT_W-1:0]       report_len
);

    gprd_pkg::report_t bytes_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              room;

    assign room = count_reg < CNT_W'(REPORT_BYTES);

    // current byte lands in its slot in the same pass
    always_comb begin
        for (int i = 0; i < gprd_pkg::KEEP_BYTES; i++) begin
            report[i] = (count_reg == CNT_W'(i)) ? data_byte : bytes_reg[i];
        end
        report_len = room ? count_reg + CNT_W'(1) : count_reg;
        count_next = last ? '0 : report_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (step_en) begin
            count_reg <= count_next;
        end
    end

    // no reset: bytes are only read after being written
    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int i = 0; i < gprd_pkg::KEEP_BYTES; i++) begin
                if (count_reg == CNT_W'(i)) begin
                    bytes_reg[i] <= data_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/gprd_decode.sv]
// ----------------------------------------------------------------------------
// gprd_decode
// decodes a finished report and keeps the held gamepad record
// ----------------------------------------------------------------------------
`default_nettype none

module gprd_decode #(
    parameter int REPORT_BYTES = gprd_pkg::REPORT_BYTES,
    parameter int CNT_W        = $clog2(REPORT_BYTES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              upd_en,
    input  wire gprd_pkg::report_t report,
    input  wire logic [CNT_W-1:0]  report_len,
    input  wire logic [1:0]        pad_kind,
    input  wire logic [7:0]        threshold,
    output gprd_pkg::result_t      result
);

    gprd_pkg::record_t held_reg;
    gprd_pkg::record_t held_next;
    logic              legacy_hit;
    logic              gip_ok;
    logic              gip_input;
    logic              gip_guide;
    logic              ack;
    logic [7:0]        lt;
    logic [7:0]        rt;

    always_comb begin
        legacy_hit = (pad_kind == gprd_pkg::KIND_LEGACY)
                  && (report_len >= CNT_W'(gprd_pkg::LEGACY_MIN_LEN))
                  && (report[0] == gprd_pkg::LEGACY_ID)
                  && (report[1] >= gprd_pkg::LEGACY_MIN_SIZE);
        gip_ok     = (pad_kind == gprd_pkg::KIND_GIP)
                  && (report_len >= CNT_W'(gprd_pkg::GIP_ACK_LEN));
        gip_input  = gip_ok && (report[0] == gprd_pkg::GIP_INPUT_ID)
                  && (report_len >= CNT_W'(gprd_pkg::GIP_INPUT_LEN));
        gip_guide  = gip_ok && (report[0] == gprd_pkg::GIP_GUIDE_ID)
                  && (report_len >= CNT_W'(gprd_pkg::GIP_GUIDE_LEN));
        ack        = gip_ok && report[1][gprd_pkg::GIP_ACK_BIT];

        // gip triggers are 10-bit words, keep bits 9..2
        lt = legacy_hit ? report[4] : {report[7][1:0], report[6][7:2]};
        rt = legacy_hit ? report[5] : {report[9][1:0], report[8][7:2]};

        held_next = held_reg;
        if (legacy_hit) begin
            held_next.buttons[7:0]   = report[2];
            held_next.buttons[9:8]   = report[3][1:0];
            held_next.buttons[gprd_pkg::BTN_GUIDE] = report[3][2];
            held_next.buttons[14:11] = report[3][7:4];
            held_next.left_x  = {report[7],  report[6]};
            held_next.left_y  = {report[9],  report[8]};
            held_next.right_x = {report[11], report[10]};
            held_next.right_y = {report[13], report[12]};
        end else if (gip_input) begin
            held_next.buttons[3:0]   = report[5][3:0];
            held_next.buttons[5:4]   = report[4][3:2];
            held_next.buttons[7:6]   = report[5][7:6];
            held_next.buttons[9:8]   = report[5][5:4];
            held_next.buttons[14:11] = report[4][7:4];
            held_next.left_x  = {report[11], report[10]};
            held_next.left_y  = {report[13], report[12]};
            held_next.right_x = {report[15], report[14]};
            held_next.right_y = {report[17], report[16]};
        end else if (gip_guide) begin
            held_next.buttons[gprd_pkg::BTN_GUIDE] = report[4][0];
        end
        if (legacy_hit || gip_input) begin
            held_next.left_trigger  = lt;
            held_next.right_trigger = rt;
            held_next.buttons[gprd_pkg::BTN_L2] = lt >= threshold;
            held_next.buttons[gprd_pkg::BTN_R2] = rt >= threshold;
        end

        result.rec           = held_next;
        result.state_changed = held_next != held_reg;
        result.ack_needed    = ack;
        result.ack_command   = ack ? report[0] : 8'h00;
        result.ack_sequence  = ack ? report[2] : 8'h00;
        result.ack_length    = ack ? report[3] : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (upd_en) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

[rtl/gamepad_report_decoder.sv]
// ----------------------------------------------------------------------------
// gamepad_report_decoder
// byte-stream decoder for usb gamepad input reports
// ----------------------------------------------------------------------------
// Report bytes come in one beat each on the s_ channel, s_tlast on the final
// byte. The block keeps the first bytes of each report and a held record of
// buttons, triggers and sticks; on the final byte it decodes the report in
// the format chosen by pad_kind (0 none, 1 legacy, 2 gip) and sends exactly
// one result beat on m_ carrying the record, a changed flag and the fields
// of an acknowledge request. Non-final bytes give no result. Each byte is
// registered at the input, goes through the buffer merge and the decode
// logic in one pass and the result is registered at the output, so a byte
// can be accepted every cycle; the only stall is a final byte waiting while
// an earlier result is still not taken. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_report_decoder #(
    parameter int REPORT_BYTES = gprd_pkg::REPORT_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // report byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // report_byte
    input  wire logic        s_tlast,   // last_byte
    // decoded result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // buttons[16:0], left_trigger[24:17], right_trigger[32:25], left_x[48:33],
    // left_y[64:49], right_x[80:65], right_y[96:81], state_changed[97],
    // ack_needed[98], ack_command[106:99], ack_sequence[114:107],
    // ack_length[122:115], zero fill above
    output logic [gprd_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(REPORT_BYTES + 1);

    // configuration
    logic [1:0] pad_kind_reg;
    logic [7:0] threshold_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // output register
    logic                               out_valid_reg;
    logic [gprd_pkg::OUT_DATA_W-1:0]    out_data_reg;

    logic                 proc_en;
    logic                 upd_en;
    gprd_pkg::report_t    report;
    logic [CNT_W-1:0]     report_len;
    gprd_pkg::result_t    result;

    // a final byte only moves on when the output register can take its result
    assign proc_en  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign upd_en   = proc_en && in_last_reg;
    assign s_tready = !in_valid_reg || proc_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_kind_reg  <= gprd_pkg::KIND_NONE;
            threshold_reg <= gprd_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                gprd_pkg::CFG_PAD_KIND:  pad_kind_reg  <= cfg_wdata[1:0];
                gprd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    gprd_buffer #(
        .REPORT_BYTES (REPORT_BYTES),
        .CNT_W        (CNT_W)
    ) u_buffer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (proc_en),
        .data_byte  (in_byte_reg),
        .last       (in_last_reg),
        .report     (report),
        .report_len (report_len)
    );

    gprd_decode #(
        .REPORT_BYTES (REPORT_BYTES),
        .CNT_W        (CNT_W)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (upd_en),
        .report     (report),
        .report_len (report_len),
        .pad_kind   (pad_kind_reg),
        .threshold  (threshold_reg),
        .result     (result)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (upd_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            out_data_reg <= {5'd0,
                             result.ack_length, result.ack_sequence, result.ack_command,
                             result.ack_needed, result.state_changed,
                             result.rec.right_y, result.rec.right_x,
                             result.rec.left_y, result.rec.left_x,
                             result.rec.right_trigger, result.rec.left_trigger,
                             result.rec.buttons};
        end
    end

    // input side only stalls behind an untaken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

    // a decoded final byte always produces a result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |=> m_tvalid)
        else $error("final byte produced no result");

    // acknowledge fields are zero unless an ack is requested
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[98]) |-> (m_tdata[122:99] == 24'd0))
        else $error("ack fields set without ack request");

    // no ack request unless the gip format is selected
    assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_en && pad_kind_reg != gprd_pkg::KIND_GIP) |-> !result.ack_needed)
        else $error("ack requested outside gip format");

endmodule

`default_nettype wire

[verif/report_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// report_decode_checker
// Watches the configuration port and both streams of the gamepad report
// decoder. Keeps its own copy of the held record and the report buffer,
// predicts the result beat of every final byte and compares each result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module report_decode_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [7:0]                        cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [gprd_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [31:0]                       fail_count,
    output logic [31:0]                       pending_results
);

    import gprd_pkg::*;

    logic [1:0] pad_kind_q;
    logic [7:0] threshold_q;
    logic [7:0] report_q [REPORT_BYTES];
    logic [4:0] byte_count_q;
    record_t    held_q;
    result_t    due_results [$];

    initial begin
        fail_count      = '0;
        pending_results = '0;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s mismatch: got %0h, want %0h", what, got, want));
        end
    endtask

    // trigger levels also drive the digital l2/r2 buttons
    task automatic load_triggers(input logic [7:0] lt, input logic [7:0] rt);
        held_q.left_trigger    = lt;
        held_q.right_trigger   = rt;
        held_q.buttons[BTN_L2] = (lt >= threshold_q);
        held_q.buttons[BTN_R2] = (rt >= threshold_q);
    endtask

    // four little endian words starting at base
    task automatic set_sticks(input int base);
        held_q.left_x  = {report_q[base + 1], report_q[base]};
        held_q.left_y  = {report_q[base + 3], report_q[base + 2]};
        held_q.right_x = {report_q[base + 5], report_q[base + 4]};
        held_q.right_y = {report_q[base + 7], report_q[base + 6]};
    endtask

    task automatic predict_byte(input logic [7:0] data, input logic fin);
        record_t     prior;
        result_t     res;
        int          n;
        logic [15:0] lw;
        logic [15:0] rw;
        // bytes past the buffer are dropped, count saturates
        if (byte_count_q < REPORT_BYTES) begin
            report_q[byte_count_q] = data;
            byte_count_q++;
        end
        if (fin) begin
            n            = byte_count_q;
            byte_count_q = '0;
            prior        = held_q;
            res          = '0;
            if (pad_kind_q == KIND_LEGACY) begin
                if (n >= LEGACY_MIN_LEN && report_q[0] == LEGACY_ID &&
                    report_q[1] >= LEGACY_MIN_SIZE) begin
                    held_q.buttons = {2'b00, report_q[3][7:4], report_q[3][2],
                                      report_q[3][1:0], report_q[2]};
                    load_triggers(report_q[4], report_q[5]);
                    set_sticks(6);
                end
            end else if (pad_kind_q == KIND_GIP && n >= GIP_ACK_LEN) begin
                if (report_q[0] == GIP_INPUT_ID && n >= GIP_INPUT_LEN) begin
                    // guide survives an input report
                    held_q.buttons = {2'b00, report_q[4][7:4], held_q.buttons[BTN_GUIDE],
                                      report_q[5][5:4], report_q[5][7:6],
                                      report_q[4][3:2], report_q[5][3:0]};
                    lw = {report_q[7], report_q[6]};
                    rw = {report_q[9], report_q[8]};
                    load_triggers(lw[9:2], rw[9:2]);
                    set_sticks(10);
                end else if (report_q[0] == GIP_GUIDE_ID && n >= GIP_GUIDE_LEN) begin
                    held_q.buttons[BTN_GUIDE] = report_q[4][0];
                end
                if (report_q[1][GIP_ACK_BIT]) begin
                    res.ack_needed   = 1'b1;
                    res.ack_command  = report_q[0];
                    res.ack_sequence = report_q[2];
                    res.ack_length   = report_q[3];
                end
            end
            res.rec           = held_q;
            res.state_changed = (held_q != prior);
            due_results.push_back(res);
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        result_t want;
        if (due_results.size() == 0) begin
            report_error($sformatf("result beat %0h with nothing expected", d));
        end else begin
            want = due_results.pop_front();
            compare_field("buttons", d[16:0], want.rec.buttons);
            compare_field("left_trigger", d[24:17], want.rec.left_trigger);
            compare_field("right_trigger", d[32:25], want.rec.right_trigger);
            compare_field("left_x", d[48:33], $unsigned(want.rec.left_x));
            compare_field("left_y", d[64:49], $unsigned(want.rec.left_y));
            compare_field("right_x", d[80:65], $unsigned(want.rec.right_x));
            compare_field("right_y", d[96:81], $unsigned(want.rec.right_y));
            compare_field("state_changed", d[97], want.state_changed);
            compare_field("ack_needed", d[98], want.ack_needed);
            compare_field("ack_command", d[106:99], want.ack_command);
            compare_field("ack_sequence", d[114:107], want.ack_sequence);
            compare_field("ack_length", d[122:115], want.ack_length);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pad_kind_q   = KIND_NONE;
            threshold_q  = THRESHOLD_RESET;
            byte_count_q = '0;
            held_q       = '0;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_PAD_KIND) begin
                    pad_kind_q = cfg_wdata[1:0];
                end else begin
                    threshold_q = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
        end
        pending_results = due_results.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives report bytes and configuration into the gamepad report decoder and
// gives the verdict. A short directed run covers every pad kind, the extreme
// bytes and thresholds, short, rejected and overlong reports; then random
// phases of mostly well formed reports with random content run under random
// source gaps and sink stalls. Checking is done by report_decode_checker.
// ----------------------------------------------------------------------------

module testbench;

    import gprd_pkg::*;

    localparam int         HALF_PERIOD  = 10;
    localparam int         QUIET_LIMIT  = 2000;  // cycles without any accepted beat
    localparam int         TARGET_BYTES = 400;
    localparam int         CALM_BYTES   = 300;   // no idling past this point
    localparam logic [1:0] KIND_UNUSED  = 2'd3;  // spare code, block ignores reports

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [7:0]              cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;   // report_byte
    logic                    s_tlast;   // last_byte
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;   // see the decoder port list for the layout
    logic [31:0]             fail_count;
    logic [31:0]             pending_results;

    // report under construction
    logic [7:0]              report_bytes [64];
    int                      report_len = 0;

    bit                      idle_on = 1'b1;
    int                      stall_left = 0;
    int                      quiet_cycles = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    gamepad_report_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    report_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // sink side: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any beat on either channel ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // one byte beat, entered and left at a falling edge; a gap may come first
    task automatic push_byte(input logic [7:0] data, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_report();
        for (int i = 0; i < report_len; i++) begin
            push_byte(report_bytes[i], i == report_len - 1);
        end
    endtask

    task automatic fill_const(input int len, input logic [7:0] value);
        report_len = len;
        for (int i = 0; i < len; i++) report_bytes[i] = value;
    endtask

    task automatic fill_random(input int len);
        report_len = len;
        for (int i = 0; i < len; i++) report_bytes[i] = 8'($urandom);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        // let the pipeline empty before touching the registers
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [1:0] kind, input logic [7:0] threshold);
        settle();
        write_reg(CFG_PAD_KIND, {6'b0, kind});
        write_reg(CFG_THRESHOLD, threshold);
    endtask

    // mostly well formed reports for the chosen kind, the rest broken or noise
    task automatic build_random_report(input logic [1:0] kind);
        int pick;
        pick = $urandom_range(0, 99);
        // resending the last report unchanged exercises the no-change case
        if (pick < 15 && report_len > 0) return;
        if (kind == KIND_LEGACY) begin
            if (pick < 75) begin
                fill_random($urandom_range(0, 7) == 0 ? $urandom_range(15, 24)
                                                      : $urandom_range(14, 18));
                report_bytes[0] = LEGACY_ID;
                report_bytes[1] = 8'($urandom_range(LEGACY_MIN_SIZE, 255));
            end else if (pick < 82) begin
                // too short to decode
                fill_random($urandom_range(1, LEGACY_MIN_LEN - 1));
                report_bytes[0] = LEGACY_ID;
            end else if (pick < 89) begin
                // size byte below the minimum
                fill_random($urandom_range(14, 18));
                report_bytes[0] = LEGACY_ID;
                report_bytes[1] = 8'($urandom_range(0, LEGACY_MIN_SIZE - 1));
            end else begin
                fill_random($urandom_range(1, 24));
            end
        end else if (kind == KIND_GIP) begin
            if (pick < 50) begin
                fill_random($urandom_range(0, 7) == 0 ? $urandom_range(19, 24)
                                                      : GIP_INPUT_LEN);
                report_bytes[0] = GIP_INPUT_ID;
            end else if (pick < 72) begin
                fill_random($urandom_range(GIP_GUIDE_LEN, 8));
                report_bytes[0] = GIP_GUIDE_ID;
            end else if (pick < 82) begin
                // input report cut short, may still ask for an ack
                fill_random($urandom_range(1, GIP_INPUT_LEN - 1));
                report_bytes[0] = GIP_INPUT_ID;
            end else if (pick < 88) begin
                fill_random($urandom_range(1, GIP_GUIDE_LEN - 1));
                report_bytes[0] = GIP_GUIDE_ID;
            end else begin
                fill_random($urandom_range(1, 24));
            end
        end else begin
            fill_random($urandom_range(1, 24));
        end
    endtask

    initial begin
        int         pick;
        int         phase_bytes;
        int         phase_goal;
        int         useful_bytes;
        logic [1:0] next_kind;
        logic [7:0] threshold;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PAD_KIND;
        cfg_wdata = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        useful_bytes = 0;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset config: no pad kind, reports come back with the record untouched
        fill_const(1, 8'h00);
        send_report();
        fill_const(1, 8'hFF);
        send_report();

        // legacy kind, threshold at its floor: every trigger counts as pressed
        configure(KIND_LEGACY, 8'h00);
        fill_const(LEGACY_MIN_LEN, 8'hFF);
        report_bytes[0] = LEGACY_ID;
        send_report();
        fill_const(LEGACY_MIN_LEN, 8'h00);
        report_bytes[1] = LEGACY_MIN_SIZE;
        send_report();
        // size byte one below the minimum, then one byte short
        fill_const(LEGACY_MIN_LEN, 8'hFF);
        report_bytes[0] = LEGACY_ID;
        report_bytes[1] = LEGACY_MIN_SIZE - 8'd1;
        send_report();
        fill_const(LEGACY_MIN_LEN - 1, 8'hFF);
        report_bytes[0] = LEGACY_ID;
        send_report();

        // gip kind, threshold at its ceiling
        configure(KIND_GIP, 8'hFF);
        fill_const(GIP_INPUT_LEN, 8'hFF);
        report_bytes[0] = GIP_INPUT_ID;
        send_report();
        fill_const(GIP_GUIDE_LEN, 8'h00);
        report_bytes[0] = GIP_GUIDE_ID;
        send_report();
        fill_const(GIP_GUIDE_LEN, 8'h00);
        report_bytes[0] = GIP_GUIDE_ID;
        report_bytes[1] = 8'h10;
        report_bytes[4] = 8'h01;
        send_report();
        // too short for an ack even with the ack bit set
        fill_const(GIP_ACK_LEN - 1, 8'h00);
        report_bytes[1] = 8'h10;
        send_report();
        // overlong input report, extra bytes dropped
        fill_const(22, 8'h00);
        report_bytes[0] = GIP_INPUT_ID;
        report_bytes[1] = 8'h10;
        send_report();

        // spare kind code ignores even a good report
        configure(KIND_UNUSED, THRESHOLD_RESET);
        fill_const(GIP_INPUT_LEN, 8'hFF);
        report_bytes[0] = GIP_INPUT_ID;
        send_report();

        // random phases, each with its own settings, drained before the next
        while (useful_bytes < TARGET_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                next_kind = KIND_NONE;
            end else if (pick == 1) begin
                next_kind = KIND_UNUSED;
            end else if (pick < 6) begin
                next_kind = KIND_LEGACY;
            end else begin
                next_kind = KIND_GIP;
            end
            if ($urandom_range(0, 3) == 0) begin
                threshold = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
                threshold = 8'($urandom);
            end
            idle_on = (useful_bytes < CALM_BYTES);
            configure(next_kind, threshold);
            phase_goal  = (next_kind == KIND_LEGACY || next_kind == KIND_GIP) ?
                          $urandom_range(60, 140) : 20;
            phase_bytes = 0;
            while (phase_bytes < phase_goal) begin
                build_random_report(next_kind);
                send_report();
                phase_bytes += report_len;
            end
            if (next_kind == KIND_LEGACY || next_kind == KIND_GIP) begin
                useful_bytes += phase_bytes;
            end
        end

        // wind down: everything predicted must come out, then a short quiet spell
        idle_on = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/gprd_pkg.sv
rtl/gprd_buffer.sv
rtl/gprd_decode.sv
rtl/gamepad_report_decoder.sv
verif/report_decode_checker.sv
verif/testbench.sv
